/* rtl/wma_pkg.sv */
// Package for the windowed moving average core: parameter defaults,
// register map constants and the sequencer state type.
// No dependencies; imported by windowed_moving_average_core.
package wma_pkg;

  // Defaults for the top-level parameters.
  localparam int DEFAULT_MAX_WINDOW  = 64;
  localparam int DEFAULT_SAMPLE_BITS = 16;

  // Register map.
  localparam int          PADDR_W          = 3;
  localparam logic [0:0]  REG_WINDOW_SIZE  = 1'b0;
  localparam int          RESET_WINDOW     = 16;

  // Fraction bits of the average.
  localparam int FRAC_BITS = 8;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_LOAD,
    ST_DIV,
    ST_DONE
  } wma_state_t;

endpackage

/* rtl/windowed_moving_average_core.sv */
// Windowed moving average core: circular sample store, running sum and a
// bit-serial restoring divider by the held sample count.
// Depends on wma_pkg.
//
//   channel  | direction | handshake               | payload
//   ---------+-----------+-------------------------+------------------------------
//   s_*      | in        | s_tvalid / s_tready     | s_tdata: sample
//   m_*      | out       | m_tvalid / m_tready     | m_tdata: average, samples_held
//   apb      | in/out    | psel, penable, pready   | window_size at byte address 0
//
// A request passes from acceptance through the store read, the sum update
// (ST_SUM), the divider load (ST_LOAD) and the divider (ST_DIV), which shifts
// out one quotient bit per cycle over AVG_W bits, to ST_DONE, which hands the
// quotient to the output register; a new request is taken only back in ST_IDLE.
// Reset (rst, synchronous, active high) clears the counters, the running sum
// and the output valid; the sample store is not cleared, since an entry is
// only read after it was written in the current warm-up.
// A stalled output holds its result; the core keeps the finished quotient
// until the output register frees, and takes no new request meanwhile.
module windowed_moving_average_core
  #(
    parameter int MAX_WINDOW  = wma_pkg::DEFAULT_MAX_WINDOW,
    parameter int SAMPLE_BITS = wma_pkg::DEFAULT_SAMPLE_BITS
  )
  (
    input  logic                        clk,
    input  logic                        rst,
    // s_tdata fields from bit 0 up: sample (SAMPLE_BITS, signed)
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0] s_tdata,
    // m_tdata fields from bit 0 up: average (SAMPLE_BITS+8, signed),
    // samples_held (clog2(MAX_WINDOW+1), unsigned)
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [((SAMPLE_BITS+wma_pkg::FRAC_BITS+$clog2(MAX_WINDOW+1)+7)/8)*8-1:0] m_tdata,
    // Configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [wma_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
  );

  import wma_pkg::*;

  // Derived widths.
  localparam int CNT_W  = $clog2(MAX_WINDOW + 1);   // counts 0..MAX_WINDOW
  localparam int ADDR_W = $clog2(MAX_WINDOW);       // store address
  localparam int SUM_W  = SAMPLE_BITS + ADDR_W;     // running sum
  localparam int AVG_W  = SAMPLE_BITS + FRAC_BITS;  // average and quotient
  localparam int OUT_W  = ((AVG_W + CNT_W + 7) / 8) * 8;
  localparam int STEP_W = $clog2(AVG_W);
  localparam int RST_WIN = (RESET_WINDOW > MAX_WINDOW) ? MAX_WINDOW : RESET_WINDOW;

  localparam logic [CNT_W-1:0]  MAX_CNT   = CNT_W'(MAX_WINDOW);
  localparam logic [CNT_W-1:0]  RST_CNT   = CNT_W'(RST_WIN);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(AVG_W - 1);

  // Configuration register and the window length that it selects. A zero
  // length counts as one sample, anything above the store depth saturates.
  logic [CNT_W-1:0] window_size;
  logic [CNT_W-1:0] n_eff;
  logic             cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready &&
                     (paddr[PADDR_W-1:2] == REG_WINDOW_SIZE);

  always_comb begin
    if (window_size == '0) begin
      n_eff = CNT_W'(1);
    end else if (window_size > MAX_CNT) begin
      n_eff = MAX_CNT;
    end else begin
      n_eff = window_size;
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[PADDR_W-1:2] == REG_WINDOW_SIZE) begin
      prdata = 32'(window_size);
    end
  end

  // Sequencer.
  wma_state_t state, state_next;

  logic [CNT_W-1:0]       fill_count;
  logic [ADDR_W-1:0]      oldest_position;
  logic signed [SUM_W-1:0] running_sum;

  logic [SAMPLE_BITS-1:0] sample_q;   // accepted sample
  logic [SAMPLE_BITS-1:0] rd_data;    // entry leaving the window
  logic                   full_q;     // window was full at acceptance
  logic [CNT_W-1:0]       held_q;     // divisor for this request

  logic [CNT_W-1:0]       rem;        // divider partial remainder
  logic [AVG_W-1:0]       dq;         // dividend bits out, quotient bits in
  logic [STEP_W-1:0]      step;
  logic                   neg;

  logic [AVG_W-1:0]       avg_out;
  logic [CNT_W-1:0]       held_out;

  logic                   accept;
  logic                   window_full;
  logic [ADDR_W-1:0]      pos;
  logic                   out_free;
  logic                   last_step;

  assign accept      = s_tvalid && s_tready;
  assign window_full = !(fill_count < n_eff);
  assign pos         = window_full ? oldest_position : fill_count[ADDR_W-1:0];
  assign out_free    = !m_tvalid || m_tready;
  assign last_step   = (step == LAST_STEP);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          state_next = ST_SUM;
        end
      end
      ST_SUM:  state_next = ST_LOAD;
      ST_LOAD: state_next = ST_DIV;
      ST_DIV: begin
        if (last_step) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Sample store: written with the new sample and read at the same address
  // in the acceptance cycle, so the read returns the entry being replaced.
  logic [SAMPLE_BITS-1:0] window_store [MAX_WINDOW];

  always_ff @(posedge clk) begin
    if (accept) begin
      window_store[pos] <= s_tdata[SAMPLE_BITS-1:0];
      rd_data           <= window_store[pos];
    end
  end

  // Window bookkeeping and running sum.
  logic [CNT_W-1:0] oldest_inc;
  assign oldest_inc = CNT_W'(oldest_position) + CNT_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size     <= RST_CNT;
      fill_count      <= '0;
      oldest_position <= '0;
      running_sum     <= '0;
    end else if (cfg_write) begin
      window_size     <= pwdata[CNT_W-1:0];
      fill_count      <= '0;
      oldest_position <= '0;
      running_sum     <= '0;
    end else begin
      if (accept) begin
        if (window_full) begin
          if (oldest_inc >= n_eff) begin
            oldest_position <= '0;
          end else begin
            oldest_position <= oldest_inc[ADDR_W-1:0];
          end
        end else begin
          fill_count <= fill_count + CNT_W'(1);
        end
      end
      if (state == ST_SUM) begin
        running_sum <= running_sum
                     + signed'({{(SUM_W-SAMPLE_BITS){sample_q[SAMPLE_BITS-1]}}, sample_q})
                     - (full_q ?
                        signed'({{(SUM_W-SAMPLE_BITS){rd_data[SAMPLE_BITS-1]}}, rd_data}) :
                        signed'(SUM_W'(0)));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sample_q <= s_tdata[SAMPLE_BITS-1:0];
      full_q   <= window_full;
      held_q   <= window_full ? n_eff : fill_count + CNT_W'(1);
    end
  end

  // Divider. The magnitude of sum*256 is split: its top bits always lie
  // below the divisor and seed the remainder, the remaining AVG_W bits
  // shift through dq, one quotient bit per cycle.
  logic [SUM_W-1:0] mag;
  logic [CNT_W:0]   trial;

  assign mag   = running_sum[SUM_W-1] ? (~running_sum + SUM_W'(1)) : running_sum;
  assign trial = {rem, dq[AVG_W-1]} - {1'b0, held_q};

  always_ff @(posedge clk) begin
    case (state)
      ST_LOAD: begin
        neg  <= running_sum[SUM_W-1];
        rem  <= CNT_W'(mag[SUM_W-1:SAMPLE_BITS]);
        dq   <= {mag[SAMPLE_BITS-1:0], {FRAC_BITS{1'b0}}};
        step <= '0;
      end
      ST_DIV: begin
        step <= step + STEP_W'(1);
        if (!trial[CNT_W]) begin
          rem <= trial[CNT_W-1:0];
          dq  <= {dq[AVG_W-2:0], 1'b1};
        end else begin
          rem <= {rem[CNT_W-2:0], dq[AVG_W-1]};
          dq  <= {dq[AVG_W-2:0], 1'b0};
        end
      end
      default: begin
      end
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      avg_out  <= neg ? (~dq + AVG_W'(1)) : dq;
      held_out <= held_q;
    end
  end

  assign m_tdata = OUT_W'({held_out, avg_out});

`ifndef NO_ASSERTIONS
  // The warm-up count never passes the selected window length.
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= n_eff)
    else $error("fill count exceeds window length");

  // The overwrite pointer stays inside the window.
  a_oldest_bound: assert property (@(posedge clk) disable iff (rst)
    CNT_W'(oldest_position) < n_eff)
    else $error("oldest position outside window");

  // The partial remainder stays below the divisor while dividing.
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (rem < held_q))
    else $error("divider remainder not below divisor");

  // A delivered result carries a held count inside the store depth.
  a_held_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (held_out != '0 && held_out <= MAX_CNT))
    else $error("samples held out of range");
`endif

endmodule

/* tb/tb_windowed_moving_average_core.sv */
// Self-checking testbench for windowed_moving_average_core: a directed table and random phases
// of samples, checked against a predictor of the running-sum moving average.
// Depends on wma_pkg and windowed_moving_average_core; needs nothing else.
module tb_windowed_moving_average_core;
  timeunit 1ns;
  timeprecision 1ps;

  import wma_pkg::*;

  localparam int MAX_WIN  = DEFAULT_MAX_WINDOW;
  localparam int S_BITS   = DEFAULT_SAMPLE_BITS;
  localparam int AVG_BITS = S_BITS + FRAC_BITS;
  localparam int CNT_BITS = $clog2(MAX_WIN + 1);
  localparam int SD_W     = ((S_BITS + 7) / 8) * 8;
  localparam int MD_W     = ((AVG_BITS + CNT_BITS + 7) / 8) * 8;

  // The window size register sits at byte address 4 * index.
  localparam logic [PADDR_W-1:0] WINDOW_ADDR = {REG_WINDOW_SIZE, 2'b00};

  // Idle odds in percent, and the receiver's long hold-off in cycles.
  localparam int IDLE_PCT   = 32;
  localparam int HOLD_LEN   = 400;
  localparam int RAND_ITEMS = 600;
  // The tail wait covers the time of two requests through the core.
  localparam int TAIL_WAIT  = 2 * (AVG_BITS + 4);

  typedef enum logic {ROW_CONFIG, ROW_SAMPLE} row_kind_t;

  typedef struct packed {
    logic [AVG_BITS-1:0] avg;
    logic [CNT_BITS-1:0] held;
  } avg_result_t;

  typedef struct packed {
    row_kind_t           kind;
    logic [31:0]         value;
    logic                typed;
    logic [AVG_BITS-1:0] avg;
    logic [CNT_BITS-1:0] held;
  } dir_row_t;

  // Directed rows. Expected values are typed in only where they are obvious: the first sample
  // after reset, and windows of one, whether set directly or by a zero.
  localparam int N_DIRECTED = 24;
  dir_row_t directed_rows [N_DIRECTED] = '{
    '{ROW_SAMPLE, 32'h0000_8000, 1'b1, 24'h800000, 7'd1},  // reset window, first sample
    '{ROW_SAMPLE, 32'h0000_8000, 1'b0, 24'h0,      7'd0},
    '{ROW_CONFIG, 32'd1,         1'b0, 24'h0,      7'd0},  // window of one
    '{ROW_SAMPLE, 32'h0000_7FFF, 1'b1, 24'h7FFF00, 7'd1},
    '{ROW_SAMPLE, 32'h0000_8000, 1'b1, 24'h800000, 7'd1},
    '{ROW_SAMPLE, 32'h0000_0000, 1'b1, 24'h000000, 7'd1},
    '{ROW_CONFIG, 32'd0,         1'b0, 24'h0,      7'd0},  // zero acts as one
    '{ROW_SAMPLE, 32'h0000_3039, 1'b1, 24'h303900, 7'd1},
    '{ROW_SAMPLE, 32'h0000_FFFF, 1'b1, 24'hFFFF00, 7'd1},
    '{ROW_CONFIG, 32'd127,       1'b0, 24'h0,      7'd0},  // saturates to the maximum
    '{ROW_SAMPLE, 32'h0000_FFFF, 1'b0, 24'h0,      7'd0},
    '{ROW_SAMPLE, 32'h0000_0001, 1'b0, 24'h0,      7'd0},
    '{ROW_SAMPLE, 32'h0000_0003, 1'b0, 24'h0,      7'd0},
    '{ROW_SAMPLE, 32'h0000_FFF9, 1'b0, 24'h0,      7'd0},  // negative mean
    '{ROW_SAMPLE, 32'h0000_7FFF, 1'b0, 24'h0,      7'd0},
    '{ROW_CONFIG, 32'd3,         1'b0, 24'h0,      7'd0},  // short window, wraps quickly
    '{ROW_SAMPLE, 32'h0000_0064, 1'b0, 24'h0,      7'd0},
    '{ROW_SAMPLE, 32'h0000_FF38, 1'b0, 24'h0,      7'd0},
    '{ROW_SAMPLE, 32'h0000_012C, 1'b0, 24'h0,      7'd0},
    '{ROW_SAMPLE, 32'h0000_8000, 1'b0, 24'h0,      7'd0},
    '{ROW_SAMPLE, 32'h0000_7FFF, 1'b0, 24'h0,      7'd0},
    '{ROW_SAMPLE, 32'h0000_FFFF, 1'b0, 24'h0,      7'd0},
    '{ROW_SAMPLE, 32'h0000_0005, 1'b0, 24'h0,      7'd0},
    '{ROW_SAMPLE, 32'h0000_FFFD, 1'b0, 24'h0,      7'd0}
  };

  logic              clk;
  logic              rst;
  logic              s_tvalid;
  logic              s_tready;
  logic [SD_W-1:0]   s_tdata;   // fields from bit 0 up: sample
  logic              m_tvalid;
  logic              m_tready;
  logic [MD_W-1:0]   m_tdata;   // fields from bit 0 up: average, samples_held
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  windowed_moving_average_core i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Predictor state: its own copy of the circular store, fill level, oldest slot, sum and the
  // window size register.
  logic [S_BITS-1:0]   window_copy [MAX_WIN];
  int                  held_count;
  int                  oldest_slot;
  longint              window_sum;
  logic [CNT_BITS-1:0] window_cfg;

  // Averages still owed by the block, oldest first.
  avg_result_t pending_averages [$];

  int  mismatches;
  int  samples_sent;
  int  results_checked;
  int  configs_written;
  bit  no_idle;       // set by the sender for a stretch where neither side idles
  bit  hold_wanted;   // the sender asks the receiver for its long hold-off once

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard limit, several times the slowest correct run.
  initial begin
    #5ms;
    $display("tb: failure");
    $finish;
  end

  // Reports a mismatch; only the first ten are printed, the rest are counted.
  function automatic void note_mismatch(input string what, input logic [31:0] expected,
                                        input logic [31:0] actual);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch %0d on %s: expected 0x%0h, got 0x%0h", mismatches, what, expected,
               actual);
  endfunction

  function automatic void restart_window(input logic [CNT_BITS-1:0] size);
    window_cfg  = size;
    held_count  = 0;
    oldest_slot = 0;
    window_sum  = 0;
  endfunction

  // Takes one accepted sample into the predictor and returns the average that it causes.
  // While the window fills, the sum grows and the divisor is the fill level; once full,
  // the oldest sample leaves the sum and the divisor is the window size.
  function automatic avg_result_t advance_window(input logic [S_BITS-1:0] raw);
    avg_result_t r;
    int          span;
    int          held_now;
    longint      quotient;
    if (window_cfg == 0)
      span = 1;
    else if (int'(window_cfg) > MAX_WIN)
      span = MAX_WIN;
    else
      span = int'(window_cfg);
    if (held_count < span) begin
      window_copy[held_count] = raw;
      window_sum += longint'($signed(raw));
      held_count++;
      held_now = held_count;
    end else begin
      window_sum -= longint'($signed(window_copy[oldest_slot]));
      window_copy[oldest_slot] = raw;
      window_sum += longint'($signed(raw));
      oldest_slot++;
      if (oldest_slot >= span)
        oldest_slot = 0;
      held_now = span;
    end
    // SystemVerilog division of signed integers truncates toward zero, as the block does.
    quotient = (window_sum * 256) / longint'(held_now);
    r.avg  = quotient[AVG_BITS-1:0];
    r.held = held_now[CNT_BITS-1:0];
    return r;
  endfunction

  // Offers one sample, with a random idle gap in front, and waits for its acceptance. The
  // valid stays high afterwards so that a following sample can go out back to back.
  task automatic send_sample(input logic [S_BITS-1:0] raw, input bit typed,
                             input avg_result_t typed_result);
    avg_result_t predicted;
    while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= SD_W'(raw);
    do @(posedge clk); while (!s_tready);
    predicted = advance_window(raw);
    pending_averages.push_back(typed ? typed_result : predicted);
    samples_sent++;
  endtask

  // Stops offering samples and waits until every owed average has come back.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (pending_averages.size() != 0)
      @(posedge clk);
  endtask

  // One register request: setup phase, then access until pready. Psel then drops before the
  // task returns, so that the next request never changes psel twice in one time step.
  task automatic apb_access(input bit is_write, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= is_write;
    paddr   <= WINDOW_ADDR;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Sets the window size while the block is idle, then reads it back.
  task automatic set_window(input logic [31:0] wdata);
    logic [31:0] rdata;
    wait_drained();
    apb_access(1'b1, wdata, rdata);
    restart_window(wdata[CNT_BITS-1:0]);
    configs_written++;
    apb_access(1'b0, 32'd0, rdata);
    if (rdata !== 32'(wdata[CNT_BITS-1:0]))
      note_mismatch("window_size readback", 32'(wdata[CNT_BITS-1:0]), rdata);
  endtask

  // Sample source per phase: mixed values, or a run of one extreme to drive the full-window
  // average to its limits.
  function automatic logic [S_BITS-1:0] pick_sample(input int mode);
    logic [31:0] r;
    int          pick;
    r    = $urandom();
    pick = $urandom_range(0, 9);
    if (mode == 1)
      return 16'h8000;
    if (mode == 2)
      return 16'h7FFF;
    case (pick)
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2, 3:    return S_BITS'($urandom_range(0, 31) - 16);
      default: return r[S_BITS-1:0];
    endcase
  endfunction

  // Receiver: checks every accepted result against the oldest owed average, idles at random,
  // and once holds off for a long stretch so the block fills up and stalls its input.
  initial begin
    avg_result_t want;
    logic [MD_W-1:0] got;
    int  stall_left;
    bit  hold_done;
    stall_left = 0;
    hold_done  = 1'b0;
    m_tready  <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) begin
        got = m_tdata;
        if (pending_averages.size() == 0) begin
          note_mismatch("unexpected result", 32'd0, 32'(got));
        end else begin
          want = pending_averages.pop_front();
          if (got[AVG_BITS-1:0] !== want.avg)
            note_mismatch("average", 32'(want.avg), 32'(got[AVG_BITS-1:0]));
          if (got[AVG_BITS +: CNT_BITS] !== want.held)
            note_mismatch("samples_held", 32'(want.held), 32'(got[AVG_BITS +: CNT_BITS]));
          if (got[MD_W-1:AVG_BITS+CNT_BITS] !== '0)
            note_mismatch("tdata padding", 32'd0, 32'(got[MD_W-1:AVG_BITS+CNT_BITS]));
        end
        results_checked++;
      end
      if (hold_wanted && !hold_done) begin
        hold_done  = 1'b1;
        stall_left = HOLD_LEN;
      end
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // Sender: reset, directed table, then random phases of window sizes and samples.
  initial begin
    avg_result_t typed_result;
    avg_result_t none;
    logic [31:0] wdata;
    int          random_sent;
    int          phase;
    int          span;
    int          count;
    int          mode;
    int          pick;

    mismatches      = 0;
    samples_sent    = 0;
    results_checked = 0;
    configs_written = 0;
    no_idle         = 1'b0;
    hold_wanted     = 1'b0;
    none            = '0;
    restart_window(CNT_BITS'(RESET_WINDOW));

    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // The directed rows start on the reset window size, so it is checked before any write.
    for (int i = 0; i < N_DIRECTED; i++) begin
      if (directed_rows[i].kind == ROW_CONFIG) begin
        set_window(directed_rows[i].value);
      end else begin
        typed_result.avg  = directed_rows[i].avg;
        typed_result.held = directed_rows[i].held;
        send_sample(directed_rows[i].value[S_BITS-1:0], directed_rows[i].typed, typed_result);
      end
    end

    // Fixed phases first cover the extremes of the register, then random sizes follow,
    // mostly small so that the window wraps many times.
    random_sent = 0;
    phase       = 0;
    while (random_sent < RAND_ITEMS) begin
      mode = 0;
      case (phase)
        0: begin wdata = 32'd64;  count = 100; end
        1: begin wdata = 32'd1;   count = 20;  end
        2: begin wdata = 32'd0;   count = 20;  end
        3: begin wdata = 32'd127; count = 80;  mode = 1; end
        4: begin wdata = 32'd65;  count = 80;  mode = 2; end
        default: begin
          pick = $urandom_range(0, 9);
          if (pick < 7)
            span = $urandom_range(1, 12);
          else if (pick < 9)
            span = $urandom_range(13, 64);
          else
            span = $urandom_range(0, 127);
          // Bits above the register are ignored by the block.
          wdata = $urandom();
          wdata[CNT_BITS-1:0] = CNT_BITS'(span);
          count = ((span == 0) ? 1 : (span > MAX_WIN) ? MAX_WIN : span) + $urandom_range(4, 24);
          if ($urandom_range(0, 9) == 0)
            mode = $urandom_range(1, 2);
        end
      endcase
      set_window(wdata);
      // One phase runs with neither side idling.
      no_idle = (phase == 2);
      for (int k = 0; k < count; k++) begin
        // In the first phase the receiver holds off while samples keep coming, and later
        // the sender itself pauses until everything has drained.
        if (phase == 0 && k == 10)
          hold_wanted = 1'b1;
        if (phase == 0 && k == 60)
          wait_drained();
        send_sample(pick_sample(mode), 1'b0, none);
        random_sent++;
      end
      no_idle = 1'b0;
      phase++;
    end

    wait_drained();
    repeat (TAIL_WAIT) @(posedge clk);
    if (pending_averages.size() != 0)
      note_mismatch("results never delivered", 32'd0, 32'(pending_averages.size()));

    $display("covered %0d samples over %0d window size settings, %0d results checked",
             samples_sent, configs_written, results_checked);
    $display("window sizes included zero, one, the maximum and values above it");
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("%0d mismatches in total", mismatches);
      $display("tb: failure");
    end
    $finish;
  end

endmodule
